@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clk edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop on every clk edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mtl_pkg.sv @@
`default_nettype none

package mtl_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 16;
   localparam int NKW = 13;
   localparam logic [3:0] KW_NONE = 4'd13;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] CSR_DROP_COMMENTS = 3'd0;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_SIGN    = 4'd1,
      MODE_INT     = 4'd2,
      MODE_FLOAT   = 4'd3,
      MODE_STRING  = 4'd4,
      MODE_IDENT   = 4'd5,
      MODE_SLASH   = 4'd6,
      MODE_COMMENT = 4'd7
   } mode_type;

   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_INVALID = 4'd1,
      KIND_INT     = 4'd2,
      KIND_FLOAT   = 4'd3,
      KIND_STR     = 4'd4,
      KIND_KEYWORD = 4'd5,
      KIND_BRACEL  = 4'd6,
      KIND_BRACER  = 4'd7,
      KIND_PARENL  = 4'd8,
      KIND_PARENR  = 4'd9,
      KIND_COMMENT = 4'd10
   } kind_type;

   typedef struct packed {
      logic        last;
      kind_type    kind;
      logic [3:0]  keyword_id;
      logic [15:0] token_length;
      logic [31:0] int_value;
      logic        int_overflow;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic token_type tok_make(kind_type kind, logic [3:0] kw, logic [15:0] len,
                                          logic [31:0] val, logic ovf);
      token_type t;
      t.last = 1'b0;
      t.kind = kind;
      t.keyword_id = kw;
      t.token_length = len;
      t.int_value = val;
      t.int_overflow = ovf;
      return t;
   endfunction

   function automatic logic [3:0] kw_len(logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd0: n = 4'd10;
         4'd1: n = 4'd11;
         4'd2: n = 4'd9;
         4'd3: n = 4'd9;
         4'd4: n = 4'd6;
         4'd5: n = 4'd4;
         4'd6: n = 4'd6;
         4'd7: n = 4'd8;
         4'd8: n = 4'd4;
         4'd9: n = 4'd7;
         4'd10: n = 4'd3;
         4'd11: n = 4'd10;
         4'd12: n = 4'd6;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(logic [3:0] k, logic [3:0] p);
      logic [127:0] t;
      logic [3:0]   idx;
      case (k)
         4'd0: t = 128'("MD5Version");
         4'd1: t = 128'("commandline");
         4'd2: t = 128'("numJoints");
         4'd3: t = 128'("numMeshes");
         4'd4: t = 128'("joints");
         4'd5: t = 128'("mesh");
         4'd6: t = 128'("shader");
         4'd7: t = 128'("numverts");
         4'd8: t = 128'("vert");
         4'd9: t = 128'("numtris");
         4'd10: t = 128'("tri");
         4'd11: t = 128'("numweights");
         4'd12: t = 128'("weight");
         default: t = '0;
      endcase
      idx = kw_len(k) - 4'd1 - p;
      return t[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mtl_csr.sv @@
`default_nettype none

module mtl_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic             drop_comments
);

   logic drop_ff;
   logic drop_in;

   assign csr_pready = 1'b1;

   always_comb begin
      drop_in = drop_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == mtl_pkg::CSR_DROP_COMMENTS) begin
         drop_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= 1'b1;
      end else begin
         drop_ff <= drop_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == mtl_pkg::CSR_DROP_COMMENTS) begin
         csr_prdata = {31'd0, drop_ff};
      end
   end

   assign drop_comments = drop_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mtl_core.sv @@
`default_nettype none
`include "assert_macros.svh"

module mtl_core #(
   parameter int LENGTH_WIDTH = mtl_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_at_end,
   input  wire logic       drop_comments,
   input  wire logic       fifo_room,
   output mtl_pkg::push_type push
);

   logic [7:0]               ch_ff;
   logic                     at_end_ff;
   logic                     valid_ff;
   logic                     valid_in;
   mtl_pkg::mode_type        mode_ff, mode_in;
   logic                     neg_ff, neg_in;
   logic [LENGTH_WIDTH-1:0]  len_ff, len_in;
   logic [31:0]              accum_ff, accum_in;
   logic                     sat_ff, sat_in;
   logic [mtl_pkg::NKW-1:0]  cand_ff, cand_in;

   logic                     adv;
   logic                     is_dig, is_alp, is_ws;
   logic [LENGTH_WIDTH-1:0]  len_grow;
   logic [15:0]              len16;
   logic [35:0]              dig_sum;
   logic [32:0]              lim;
   logic                     sat_hit;
   logic [31:0]              add_accum;
   logic [mtl_pkg::NKW-1:0]  cand_filt, bg_filt;
   logic [3:0]               kw_hit;

   logic                     fl_valid;
   mtl_pkg::token_type       fl_tok;
   logic                     bg_valid;
   mtl_pkg::token_type       bg_tok;
   mtl_pkg::mode_type        bg_mode;
   logic                     bg_neg;
   logic [LENGTH_WIDTH-1:0]  bg_len;
   logic [31:0]              bg_accum;
   logic [mtl_pkg::NKW-1:0]  bg_cand;

   logic                     take_fl, restart, sk_valid;
   mtl_pkg::token_type       sk_tok;

   assign adv = valid_ff && fifo_room;
   assign req_ready = !valid_ff || fifo_room;
   assign valid_in = (req_valid && req_ready) ? 1'b1 : (adv ? 1'b0 : valid_ff);

   assign is_dig = ch_ff >= "0" && ch_ff <= "9";
   assign is_alp = (ch_ff >= "a" && ch_ff <= "z") || (ch_ff >= "A" && ch_ff <= "Z");
   assign is_ws = ch_ff == " " || ch_ff == 8'h0A || ch_ff == 8'h09 || ch_ff == 8'h0D;
   assign len_grow = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   generate
      if (LENGTH_WIDTH > 16) begin : g_len_sat
         assign len16 = (len_ff[LENGTH_WIDTH-1:16] != '0) ? 16'hFFFF : len_ff[15:0];
      end else begin : g_len_ext
         assign len16 = 16'(len_ff);
      end
   endgenerate

   assign lim = neg_ff ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
   assign dig_sum = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1) + {32'd0, ch_ff[3:0]};
   assign sat_hit = dig_sum > {3'd0, lim};
   assign add_accum = sat_hit ? lim[31:0] : dig_sum[31:0];

   always_comb begin
      for (int k = 0; k < mtl_pkg::NKW; k++) begin
         cand_filt[k] = cand_ff[k] && (len_ff < LENGTH_WIDTH'(mtl_pkg::kw_len(4'(k))))
            && (mtl_pkg::kw_char(4'(k), len_ff[3:0]) == ch_ff);
         bg_filt[k] = mtl_pkg::kw_char(4'(k), 4'd0) == ch_ff;
      end
      kw_hit = mtl_pkg::KW_NONE;
      for (int k = mtl_pkg::NKW - 1; k >= 0; k--) begin
         if (cand_ff[k] && len_ff == LENGTH_WIDTH'(mtl_pkg::kw_len(4'(k)))) begin
            kw_hit = 4'(k);
         end
      end
   end

   // token ended by lookahead, by a comment's newline or by end of file
   always_comb begin
      fl_valid = 1'b0;
      fl_tok = mtl_pkg::tok_make(mtl_pkg::KIND_END, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);
      case (mode_ff)
         mtl_pkg::MODE_SIGN, mtl_pkg::MODE_SLASH, mtl_pkg::MODE_STRING: begin
            fl_valid = 1'b1;
            fl_tok = mtl_pkg::tok_make(mtl_pkg::KIND_INVALID, mtl_pkg::KW_NONE, len16,
                                       32'd0, 1'b0);
         end
         mtl_pkg::MODE_INT: begin
            fl_valid = 1'b1;
            fl_tok = mtl_pkg::tok_make(mtl_pkg::KIND_INT, mtl_pkg::KW_NONE, len16,
                                       neg_ff ? (32'd0 - accum_ff) : accum_ff, sat_ff);
         end
         mtl_pkg::MODE_FLOAT: begin
            fl_valid = 1'b1;
            fl_tok = mtl_pkg::tok_make(mtl_pkg::KIND_FLOAT, mtl_pkg::KW_NONE, len16,
                                       32'd0, 1'b0);
         end
         mtl_pkg::MODE_IDENT: begin
            fl_valid = 1'b1;
            fl_tok = mtl_pkg::tok_make((kw_hit == mtl_pkg::KW_NONE) ? mtl_pkg::KIND_STR
                                       : mtl_pkg::KIND_KEYWORD, kw_hit, len16, 32'd0, 1'b0);
         end
         mtl_pkg::MODE_COMMENT: begin
            fl_valid = !drop_comments;
            fl_tok = mtl_pkg::tok_make(mtl_pkg::KIND_COMMENT, mtl_pkg::KW_NONE, len16,
                                       32'd0, 1'b0);
         end
         default: begin
            fl_valid = 1'b0;
         end
      endcase
   end

   // start of a new token from the current character
   always_comb begin
      bg_mode = mtl_pkg::MODE_IDLE;
      bg_neg = 1'b0;
      bg_len = '0;
      bg_accum = '0;
      bg_cand = '1;
      bg_valid = 1'b0;
      bg_tok = mtl_pkg::tok_make(mtl_pkg::KIND_INVALID, mtl_pkg::KW_NONE, 16'd1, 32'd0, 1'b0);
      if (is_ws) begin
         bg_mode = mtl_pkg::MODE_IDLE;
      end else if (ch_ff == "-" || ch_ff == "+") begin
         bg_mode = mtl_pkg::MODE_SIGN;
         bg_neg = ch_ff == "-";
         bg_len = LENGTH_WIDTH'(1);
      end else if (ch_ff == ".") begin
         bg_mode = mtl_pkg::MODE_FLOAT;
         bg_len = LENGTH_WIDTH'(1);
      end else if (is_dig) begin
         bg_mode = mtl_pkg::MODE_INT;
         bg_len = LENGTH_WIDTH'(1);
         bg_accum = {28'd0, ch_ff[3:0]};
      end else if (ch_ff == 8'h22) begin
         bg_mode = mtl_pkg::MODE_STRING;
      end else if (ch_ff == "{") begin
         bg_valid = 1'b1;
         bg_tok = mtl_pkg::tok_make(mtl_pkg::KIND_BRACEL, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);
      end else if (ch_ff == "}") begin
         bg_valid = 1'b1;
         bg_tok = mtl_pkg::tok_make(mtl_pkg::KIND_BRACER, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);
      end else if (ch_ff == "(") begin
         bg_valid = 1'b1;
         bg_tok = mtl_pkg::tok_make(mtl_pkg::KIND_PARENL, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);
      end else if (ch_ff == ")") begin
         bg_valid = 1'b1;
         bg_tok = mtl_pkg::tok_make(mtl_pkg::KIND_PARENR, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);
      end else if (is_alp) begin
         bg_mode = mtl_pkg::MODE_IDENT;
         bg_len = LENGTH_WIDTH'(1);
         bg_cand = bg_filt;
      end else if (ch_ff == "/") begin
         bg_mode = mtl_pkg::MODE_SLASH;
         bg_len = LENGTH_WIDTH'(1);
      end else begin
         bg_valid = 1'b1;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      neg_in = neg_ff;
      len_in = len_ff;
      accum_in = accum_ff;
      sat_in = sat_ff;
      cand_in = cand_ff;
      take_fl = 1'b0;
      restart = 1'b0;
      sk_valid = 1'b0;
      sk_tok = mtl_pkg::tok_make(mtl_pkg::KIND_END, mtl_pkg::KW_NONE, 16'd0, 32'd0, 1'b0);

      if (at_end_ff) begin
         take_fl = 1'b1;
         sk_valid = 1'b1;
         mode_in = mtl_pkg::MODE_IDLE;
         neg_in = 1'b0;
         len_in = '0;
         accum_in = '0;
         sat_in = 1'b0;
         cand_in = '1;
      end else begin
         case (mode_ff)
            mtl_pkg::MODE_SIGN: begin
               if (ch_ff == ".") begin
                  mode_in = mtl_pkg::MODE_FLOAT;
                  len_in = len_grow;
               end else if (is_dig) begin
                  mode_in = mtl_pkg::MODE_INT;
                  len_in = len_grow;
                  accum_in = add_accum;
                  sat_in = sat_ff || sat_hit;
               end else begin
                  restart = 1'b1;
               end
            end
            mtl_pkg::MODE_INT: begin
               if (is_dig) begin
                  len_in = len_grow;
                  accum_in = add_accum;
                  sat_in = sat_ff || sat_hit;
               end else if (ch_ff == ".") begin
                  mode_in = mtl_pkg::MODE_FLOAT;
                  len_in = len_grow;
               end else begin
                  restart = 1'b1;
               end
            end
            mtl_pkg::MODE_FLOAT: begin
               if (is_dig) begin
                  len_in = len_grow;
               end else begin
                  restart = 1'b1;
               end
            end
            mtl_pkg::MODE_STRING: begin
               if (ch_ff == 8'h22) begin
                  sk_valid = 1'b1;
                  sk_tok = mtl_pkg::tok_make(mtl_pkg::KIND_STR, mtl_pkg::KW_NONE, len16,
                                             32'd0, 1'b0);
                  mode_in = mtl_pkg::MODE_IDLE;
                  neg_in = 1'b0;
                  len_in = '0;
                  accum_in = '0;
                  sat_in = 1'b0;
                  cand_in = '1;
               end else begin
                  len_in = len_grow;
               end
            end
            mtl_pkg::MODE_IDENT: begin
               if (is_alp || is_dig || ch_ff == "_") begin
                  cand_in = cand_filt;
                  len_in = len_grow;
               end else begin
                  restart = 1'b1;
               end
            end
            mtl_pkg::MODE_SLASH: begin
               if (ch_ff == "/") begin
                  mode_in = mtl_pkg::MODE_COMMENT;
                  len_in = len_grow;
               end else begin
                  restart = 1'b1;
               end
            end
            mtl_pkg::MODE_COMMENT: begin
               if (ch_ff == 8'h0A) begin
                  take_fl = 1'b1;
                  mode_in = mtl_pkg::MODE_IDLE;
                  neg_in = 1'b0;
                  len_in = '0;
                  accum_in = '0;
                  sat_in = 1'b0;
                  cand_in = '1;
               end else begin
                  len_in = len_grow;
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase
         if (restart) begin
            take_fl = 1'b1;
            sk_valid = bg_valid;
            sk_tok = bg_tok;
            mode_in = bg_mode;
            neg_in = bg_neg;
            len_in = bg_len;
            accum_in = bg_accum;
            sat_in = 1'b0;
            cand_in = bg_cand;
         end
      end
   end

   // pack up to two records, mark the final one
   always_comb begin
      push.count = 2'd0;
      push.tok0 = sk_tok;
      push.tok1 = sk_tok;
      if (take_fl && fl_valid) begin
         push.tok0 = fl_tok;
         push.count = sk_valid ? 2'd2 : 2'd1;
      end else begin
         push.count = sk_valid ? 2'd1 : 2'd0;
      end
      if (push.count == 2'd2) begin
         push.tok1.last = 1'b1;
      end else begin
         push.tok0.last = 1'b1;
      end
      if (!adv) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff <= req_ch;
         at_end_ff <= req_at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff <= mtl_pkg::MODE_IDLE;
         neg_ff <= 1'b0;
         len_ff <= '0;
         accum_ff <= '0;
         sat_ff <= 1'b0;
         cand_ff <= '1;
      end else begin
         valid_ff <= valid_in;
         if (adv) begin
            mode_ff <= mode_in;
            neg_ff <= neg_in;
            len_ff <= len_in;
            accum_ff <= accum_in;
            sat_ff <= sat_in;
            cand_ff <= cand_in;
         end
      end
   end

   `ASSERT_RST(a_end_emits, clock, reset, (adv && at_end_ff) |-> (push.count != 2'd0), "end of file beat produced no record")
   `ASSERT_RST(a_end_idles, clock, reset, (adv && at_end_ff) |=> (mode_ff == mtl_pkg::MODE_IDLE && len_ff == '0), "lexer not idle after end of file")
   `ASSERT_RST(a_accum_range, clock, reset, (accum_ff <= 32'h8000_0000), "integer magnitude above saturation limit")

endmodule

`default_nettype wire

@@ hw/rtl/mtl_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"

module mtl_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mtl_pkg::push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output mtl_pkg::token_type     head
);

   mtl_pkg::token_type                   mem [mtl_pkg::FIFO_DEPTH];
   logic [mtl_pkg::FIFO_PTR_WIDTH-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [mtl_pkg::FIFO_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                                 pop;

   assign out_valid = count_ff != '0;
   assign pop = out_valid && out_ready;
   assign room = count_ff <= mtl_pkg::FIFO_CNT_WIDTH'(mtl_pkg::FIFO_DEPTH - 2);
   assign head = mem[rd_ff];

   assign wr_in = wr_ff + mtl_pkg::FIFO_PTR_WIDTH'(push.count);
   assign rd_in = rd_ff + mtl_pkg::FIFO_PTR_WIDTH'(pop);
   assign count_in = count_ff + mtl_pkg::FIFO_CNT_WIDTH'(push.count)
                     - mtl_pkg::FIFO_CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ff + 1'b1] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_RST(a_count_bound, clock, reset, (count_ff <= mtl_pkg::FIFO_CNT_WIDTH'(mtl_pkg::FIFO_DEPTH)), "queue count above depth")
   `ASSERT_RST(a_push_room, clock, reset, (push.count != 2'd0) |-> room, "records pushed without room")
   `ASSERT_RST(a_ptr_gap, clock, reset, (wr_ff - rd_ff) == mtl_pkg::FIFO_PTR_WIDTH'(count_ff), "pointers disagree with count")

endmodule

`default_nettype wire

@@ hw/rtl/mesh_text_lexer.sv @@
// Streaming tokenizer for mesh text files.
// Input channel req_*: one beat per character (req_ch) or an end-of-file
// beat (req_at_end = 1) that flushes the pending token and emits END.
// Result channel rsp_*: one token record per beat; rsp_last marks the
// final record caused by an input beat. A beat yields zero, one or two
// records, since a token ended by lookahead is sent before the record of
// the character that ended it.
// A record is offered once its beat has passed the input register and the
// lexer step into a four-entry result queue; that step waits for room.
// Throughput: one input beat per cycle while the queue holds at most two
// records; the result side drains one record per cycle on rsp_ready.
// A stall on rsp_ready fills the queue and then holds req_ready low.
// CSR: drop_comments at byte address 0 (reset 1); pready is tied high.
// Reset clears the lexer to idle between tokens and empties the queue.
`default_nettype none

module mesh_text_lexer #(
   parameter int LENGTH_WIDTH = mtl_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_at_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_last,
   output logic [3:0]       rsp_token_kind,
   output logic [3:0]       rsp_keyword_id,
   output logic [15:0]      rsp_token_length,
   output logic signed [31:0] rsp_int_value,
   output logic             rsp_int_overflow,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                drop_comments;
   logic                fifo_room;
   mtl_pkg::push_type   push;
   mtl_pkg::token_type  head;

   mtl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .drop_comments (drop_comments)
   );

   mtl_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_at_end    (req_at_end),
      .drop_comments (drop_comments),
      .fifo_room     (fifo_room),
      .push          (push)
   );

   mtl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_last = head.last;
   assign rsp_token_kind = head.kind;
   assign rsp_keyword_id = head.keyword_id;
   assign rsp_token_length = head.token_length;
   assign rsp_int_value = head.int_value;
   assign rsp_int_overflow = head.int_overflow;

endmodule

`default_nettype wire
